// ===== src/voice_table_sample_mixer_defines.svh =====
// ---------------------------------------------------------------------------
// Voice table sample mixer assertion macros
// Shared concurrent assertion forms for the mixer RTL.
// ---------------------------------------------------------------------------
`ifndef VOICE_TABLE_SAMPLE_MIXER_DEFINES_SVH
`define VOICE_TABLE_SAMPLE_MIXER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define VTSM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define VTSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/vtsm_pkg.sv =====
// ---------------------------------------------------------------------------
// Voice table sample mixer package
// Shared action codes and widths for the mixer.
// ---------------------------------------------------------------------------
`default_nettype none
package vtsm_pkg;
   localparam logic [2:0] ACT_TICK = 3'd0;
   localparam logic [2:0] ACT_LOAD = 3'd1;
   localparam logic [2:0] ACT_PLAY_ONCE = 3'd2;
   localparam logic [2:0] ACT_PLAY_LOOP = 3'd3;
   localparam logic [2:0] ACT_STOP = 3'd4;
   localparam int MIX_W = 22;
   localparam int GAIN_MAX = 1024;
   localparam int MASTER_MAX = 256;
   localparam int SLOT_W = 12 + 13 + 13 + 11 + 1 + 16;
endpackage
`default_nettype wire

// ===== src/vtsm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module vtsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/voice_table_sample_mixer.sv =====
// ---------------------------------------------------------------------------
// Voice table sample mixer
// Mixes up to MAX_VOICES sample voices held in a slot memory.
// ---------------------------------------------------------------------------
// Channel   Ports                               Handshake
// request   req_* payload, start                accepted when start && !busy
// response  rsp_* payload, rsp_valid            one cycle strobe, no stall
// config    csr_we, csr_wdata                   written when csr_we is high
//
// A tick visits every slot in turn. A slot that plays goes through slot read,
// sample read, first product, and second product with accumulate and write
// back; an empty or finished slot goes through the slot read and check only.
// A stop visits every slot, a play ends at the first free slot, a load writes
// one sample, and a refused play or an unused action goes straight to the
// result.
// The next item can be accepted in the strobe cycle.
// The slot table is cleared by a pass over every slot after reset,
// during which busy stays high. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "voice_table_sample_mixer_defines.svh"
module voice_table_sample_mixer #(
   parameter int MAX_VOICES = 16,
   parameter int SAMPLE_DEPTH = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [2:0]         req_action,
   input  wire logic [11:0]        req_sample_address,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic [12:0]        req_sound_length,
   input  wire logic [10:0]        req_voice_gain,
   input  wire logic [15:0]        req_voice_id,
   input  wire logic               csr_we,
   input  wire logic [8:0]         csr_wdata,
   output      logic               rsp_valid,
   output      logic signed [21:0] rsp_mix_sample,
   output      logic [15:0]        rsp_assigned_id,
   output      logic               rsp_accepted,
   output      logic [4:0]         rsp_live_count
);
   localparam int SW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int CW = $clog2(MAX_VOICES + 1);

   // State codes of the sequencer.
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RD    = 4'd2;   // slot read issued
   localparam logic [3:0] ST_SMP   = 4'd3;   // slot data back, sample read issued
   localparam logic [3:0] ST_MUL   = 4'd4;   // sample back, first product
   localparam logic [3:0] ST_ACC   = 4'd5;   // second product, accumulate, write back
   localparam logic [3:0] ST_DONE  = 4'd6;
   localparam logic [3:0] ST_LOAD  = 4'd7;

   // Slot word layout: live in a flop vector; the memory holds the rest.
   localparam int W = vtsm_pkg::SLOT_W;

   logic [3:0]      state_ff, state_in;
   logic [SW-1:0]   idx_ff, idx_in;
   logic [2:0]      act_ff, act_in;
   logic [11:0]     addr_ff, addr_in;
   logic [12:0]     len_ff, len_in;
   logic [10:0]     gain_ff, gain_in;
   logic [15:0]     vid_ff, vid_in;
   logic [15:0]     next_id_ff, next_id_in;
   logic [8:0]      master_ff;
   logic [MAX_VOICES-1:0] live_ff, live_in;
   logic signed [23:0] acc_ff, acc_in;
   logic            hit_ff, hit_in;
   logic            found_ff, found_in;
   logic signed [26:0] prod1_ff;
   logic signed [26:0] prod1_in;
   logic [W-1:0]    slot_q;
   logic [W-1:0]    slot_hold_ff;
   logic            slot_we;
   logic [W-1:0]    slot_wd;
   logic [15:0]     smp_q;
   logic            smp_we;
   logic [AW-1:0]   smp_rd_addr;
   logic [CW-1:0]   live_cnt;

   // Slot fields as read from the slot memory.
   logic [11:0] f_start;
   logic [12:0] f_len, f_cur, cur_use;
   logic [10:0] f_gain;
   logic        f_loop;
   logic [15:0] f_id;
   always_comb begin
      {f_start, f_len, f_cur, f_gain, f_loop, f_id} = slot_q;
   end

   // Slot fields as held for the multiply and write back stages.
   logic [11:0] h_start;
   logic [12:0] h_len, h_cur;
   logic [10:0] h_gain;
   logic        h_loop;
   logic [15:0] h_id;
   always_comb begin
      {h_start, h_len, h_cur, h_gain, h_loop, h_id} = slot_hold_ff;
   end

   logic last;
   assign last = (idx_ff == SW'(MAX_VOICES - 1));

   always_comb begin
      live_cnt = '0;
      for (int i = 0; i < MAX_VOICES; i++) begin
         live_cnt = live_cnt + CW'(live_ff[i]);
      end
   end

   logic [8:0] m_eff;
   assign m_eff = (master_ff > 9'd256) ? 9'd256 : master_ff;

   // Term of the current slot, floor of s*g*m/65536 via arithmetic shift.
   logic signed [36:0] prod2;
   assign prod2 = prod1_ff * $signed({1'b0, m_eff});

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      act_in = act_ff;
      addr_in = addr_ff;
      len_in = len_ff;
      gain_in = gain_ff;
      vid_in = vid_ff;
      next_id_in = next_id_ff;
      live_in = live_ff;
      acc_in = acc_ff;
      hit_in = hit_ff;
      found_in = found_ff;
      slot_we = 1'b0;
      slot_wd = slot_q;
      smp_we = 1'b0;
      cur_use = (f_cur >= f_len) ? 13'd0 : f_cur;
      smp_rd_addr = AW'(({1'b0, f_start} + {1'b0, cur_use}));
      prod1_in = $signed(smp_q) * $signed({1'b0, h_gain});
      unique case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_wd = '0;
            idx_in = idx_ff + SW'(1);
            if (last) begin
               state_in = ST_IDLE;
               idx_in = '0;
            end
         end
         ST_IDLE: begin
            if (start) begin
               act_in = req_action;
               addr_in = req_sample_address;
               len_in = req_sound_length;
               gain_in = (req_voice_gain > 11'd1024) ? 11'd1024 : req_voice_gain;
               vid_in = req_voice_id;
               idx_in = '0;
               acc_in = '0;
               hit_in = 1'b0;
               found_in = 1'b0;
               if (req_action == vtsm_pkg::ACT_LOAD) begin
                  smp_we = 1'b1;
                  state_in = ST_LOAD;
               end else if (req_action == vtsm_pkg::ACT_TICK ||
                            req_action == vtsm_pkg::ACT_STOP ||
                            ((req_action == vtsm_pkg::ACT_PLAY_ONCE ||
                              req_action == vtsm_pkg::ACT_PLAY_LOOP) &&
                             req_sound_length != 13'd0)) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOAD: state_in = ST_DONE;
         ST_RD: begin
            // Slot read address is idx_ff; data arrives next cycle.
            state_in = ST_SMP;
         end
         ST_SMP: begin
            unique case (act_ff)
               vtsm_pkg::ACT_TICK: begin
                  if (live_ff[idx_ff] && (f_cur < f_len || f_loop)) begin
                     state_in = ST_MUL;
                  end else begin
                     // A live one-shot voice that has already played out retires here.
                     if (live_ff[idx_ff]) begin
                        live_in[idx_ff] = 1'b0;
                     end
                     state_in = last ? ST_DONE : ST_RD;
                     idx_in = idx_ff + SW'(1);
                  end
               end
               vtsm_pkg::ACT_STOP: begin
                  if (vid_ff != 16'd0 && live_ff[idx_ff] && f_id == vid_ff) begin
                     slot_we = 1'b1;
                     slot_wd = {f_start, f_len, f_cur, f_gain, 1'b0, f_id};
                     hit_in = 1'b1;
                  end
                  state_in = last ? ST_DONE : ST_RD;
                  idx_in = idx_ff + SW'(1);
               end
               vtsm_pkg::ACT_PLAY_ONCE, vtsm_pkg::ACT_PLAY_LOOP: begin
                  if (!live_ff[idx_ff]) begin
                     slot_we = 1'b1;
                     live_in[idx_ff] = 1'b1;
                     found_in = 1'b1;
                     if (act_ff == vtsm_pkg::ACT_PLAY_LOOP) begin
                        slot_wd = {addr_ff, len_ff, 13'd0, gain_ff, 1'b1, next_id_ff};
                        next_id_in = (next_id_ff == 16'hFFFF) ? 16'd1 : next_id_ff + 16'd1;
                     end else begin
                        slot_wd = {addr_ff, len_ff, 13'd0, gain_ff, 1'b0, 16'd0};
                     end
                     state_in = ST_DONE;
                  end else begin
                     state_in = last ? ST_DONE : ST_RD;
                     idx_in = idx_ff + SW'(1);
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            acc_in = acc_ff + 24'(prod2 >>> 16);
            slot_we = 1'b1;
            cur_use = ((h_cur >= h_len) ? 13'd0 : h_cur) + 13'd1;
            slot_wd = {h_start, h_len, cur_use, h_gain, h_loop, h_id};
            if (!h_loop && cur_use >= h_len) begin
               live_in[idx_ff] = 1'b0;
            end
            state_in = last ? ST_DONE : ST_RD;
            idx_in = idx_ff + SW'(1);
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sample read address latched from the slot data in ST_SMP.
   logic [AW-1:0] smp_addr_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_SMP) begin
         smp_addr_ff <= smp_rd_addr;
         slot_hold_ff <= slot_q;
      end
      if (state_ff == ST_MUL) begin
         prod1_ff <= prod1_in;
      end
   end

   // Sample read is issued in ST_SMP straight from the slot data; the latched address holds it afterwards.
   logic [AW-1:0] smp_addr_mux;
   assign smp_addr_mux = (state_ff == ST_SMP) ? smp_rd_addr : smp_addr_ff;

   vtsm_ram #(.WIDTH(W), .DEPTH(MAX_VOICES)) u_slots (
      .clock(clock), .wr_en(slot_we), .wr_addr(idx_ff), .wr_data(slot_wd),
      .rd_addr(idx_ff), .rd_data(slot_q)
   );

   vtsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_samples (
      .clock(clock), .wr_en(smp_we), .wr_addr(AW'(req_sample_address)),
      .wr_data(req_sample_value), .rd_addr(smp_addr_mux), .rd_data(smp_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         next_id_ff <= 16'd1;
         master_ff <= 9'd256;
         live_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         next_id_ff <= next_id_in;
         live_ff <= live_in;
         if (csr_we) begin
            master_ff <= csr_wdata;
         end
         rsp_valid <= (state_ff == ST_DONE);
      end
      act_ff <= act_in;
      addr_ff <= addr_in;
      len_ff <= len_in;
      gain_ff <= gain_in;
      vid_ff <= vid_in;
      acc_ff <= acc_in;
      hit_ff <= hit_in;
      found_ff <= found_in;
      if (state_ff == ST_SMP && found_in && !found_ff &&
          act_ff == vtsm_pkg::ACT_PLAY_LOOP) begin
         rsp_assigned_id <= next_id_ff;
      end else if (state_ff == ST_IDLE) begin
         rsp_assigned_id <= 16'd0;
      end
      if (state_ff == ST_DONE) begin
         if (act_ff == vtsm_pkg::ACT_TICK) begin
            rsp_mix_sample <= (acc_ff > 24'sd2097151) ? 22'sd2097151 :
                              (acc_ff < -24'sd2097152) ? -22'sd2097152 : acc_ff[21:0];
         end else begin
            rsp_mix_sample <= '0;
         end
         rsp_accepted <= (act_ff == vtsm_pkg::ACT_STOP) ? hit_ff :
                         ((act_ff == vtsm_pkg::ACT_PLAY_ONCE ||
                           act_ff == vtsm_pkg::ACT_PLAY_LOOP) ? found_ff : 1'b0);
         rsp_live_count <= (32'(live_cnt) > 32'd31) ? 5'd31 : 5'(live_cnt);
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `VTSM_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == ST_DONE, rsp_valid)
   `VTSM_ASSERT_IMP(a_busy_on_rsp, clock, reset, rsp_valid, state_ff == ST_IDLE)
   `VTSM_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
endmodule
`default_nettype wire
